### sv/fpa_pkg.sv
package fpa_pkg;

  localparam int WORD_W    = 32;
  localparam int FRAC_BITS = 8;

  // operation codes
  typedef enum logic [2:0] {
    ACT_ADD = 3'd0,
    ACT_SUB = 3'd1,
    ACT_MUL = 3'd2,
    ACT_DIV = 3'd3,
    ACT_CMP = 3'd4,
    ACT_INC = 3'd5,
    ACT_DEC = 3'd6
  } action_t;

  // sideband that travels with each transaction through the divider pipe
  typedef struct packed {
    logic                     valid;
    logic [2:0]               action;
    logic                     neg_q;
    logic                     dz;
    logic signed [WORD_W-1:0] result;
    logic                     lt;
    logic                     eq;
    logic                     gt;
  } side_t;

endpackage

### sv/fpa_if.sv
interface fpa_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         action;
  logic signed [31:0] operand_a;
  logic signed [31:0] operand_b;

  modport source (output valid, action, operand_a, operand_b, input ready);
  modport sink   (input valid, action, operand_a, operand_b, output ready);
endinterface

interface fpa_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] result_value;
  logic               less_flag;
  logic               equal_flag;
  logic               greater_flag;
  logic               divide_by_zero;

  modport source (output valid, result_value, less_flag, equal_flag, greater_flag,
                  divide_by_zero, input ready);
  modport sink   (input valid, result_value, less_flag, equal_flag, greater_flag,
                  divide_by_zero, output ready);
endinterface

### sv/fpa_div_pipe.sv
module fpa_div_pipe #(
  parameter int FRAC_BITS = fpa_pkg::FRAC_BITS
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        en,
  input  fpa_pkg::side_t                              in_side,
  input  logic [fpa_pkg::WORD_W+FRAC_BITS-1:0]        in_dvd,
  input  logic [fpa_pkg::WORD_W-1:0]                  in_dsr,
  output fpa_pkg::side_t                              out_side,
  output logic [fpa_pkg::WORD_W+FRAC_BITS-1:0]        out_quo
);
  import fpa_pkg::*;

  localparam int DVD_W = WORD_W + FRAC_BITS;

  side_t             side_r [0:DVD_W];
  logic [DVD_W-1:0]  dvd_r  [0:DVD_W];
  logic [WORD_W-1:0] dsr_r  [0:DVD_W];
  logic [WORD_W-1:0] rem_r  [0:DVD_W];

  // input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r[0].valid <= 1'b0;
    end else if (en) begin
      side_r[0] <= in_side;
      dvd_r[0]  <= in_dvd;
      dsr_r[0]  <= in_dsr;
      rem_r[0]  <= '0;
    end
  end

  // one restoring quotient bit per stage, quotient shifts into the dividend word
  for (genvar i = 0; i < DVD_W; i++) begin : g_stage
    logic [WORD_W:0]   trial;
    logic [WORD_W:0]   diff;
    logic              qbit;
    logic [WORD_W-1:0] rem_nxt;
    logic [DVD_W-1:0]  dvd_nxt;

    always_comb begin
      trial   = {rem_r[i], dvd_r[i][DVD_W-1]};
      diff    = trial - {1'b0, dsr_r[i]};
      qbit    = ~diff[WORD_W];
      rem_nxt = qbit ? diff[WORD_W-1:0] : trial[WORD_W-1:0];
      dvd_nxt = {dvd_r[i][DVD_W-2:0], qbit};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        side_r[i+1].valid <= 1'b0;
      end else if (en) begin
        side_r[i+1] <= side_r[i];
        dvd_r[i+1]  <= dvd_nxt;
        dsr_r[i+1]  <= dsr_r[i];
        rem_r[i+1]  <= rem_nxt;
      end
    end
  end

  assign out_side = side_r[DVD_W];
  assign out_quo  = dvd_r[DVD_W];

endmodule

### sv/fixed_point_q24_8_alu_top.sv
// channel   dir  signals
// in_ch     in   valid, ready, action, operand_a, operand_b
// out_ch    out  valid, ready, result_value, less/equal/greater_flag, divide_by_zero
//
// one transaction per cycle while the pipe is not stalled (Q24.8 operands by default);
// the divider resolves one quotient bit per pipeline stage
// rst_n is synchronous, active low, and clears all stage valid bits
// the whole pipe advances when the output register is empty or taken;
// in_ch.ready follows that same enable, so a stall holds every stage in place
module fixed_point_q24_8_alu_top #(
  parameter int FRAC_BITS = fpa_pkg::FRAC_BITS
) (
  input  logic          clk,
  input  logic          rst_n,
  fpa_in_if.sink        in_ch,
  fpa_out_if.source     out_ch
);
  import fpa_pkg::*;

  localparam int DVD_W = WORD_W + FRAC_BITS;

  logic en;

  // input register
  logic                     a_valid_r;
  logic [2:0]               a_action_r;
  logic signed [WORD_W-1:0] a_opa_r;
  logic signed [WORD_W-1:0] a_opb_r;

  // operate stage
  side_t                    b_side_r;
  side_t                    b_side_nxt;
  logic signed [2*WORD_W-1:0] b_prod_r;
  logic [DVD_W-1:0]         b_dvd_r;
  logic [DVD_W-1:0]         b_dvd_nxt;
  logic [WORD_W-1:0]        b_dsr_r;
  logic [WORD_W-1:0]        b_dsr_nxt;
  logic [WORD_W-1:0]        a_mag;

  // divider interface
  side_t                    div_in_side;
  side_t                    div_out_side;
  logic [DVD_W-1:0]         div_quo;
  logic signed [2*WORD_W-1:0] prod_shift;

  // output register
  logic                     out_valid_r;
  logic signed [WORD_W-1:0] out_result_r;
  logic                     out_lt_r;
  logic                     out_eq_r;
  logic                     out_gt_r;
  logic                     out_dz_r;
  logic [DVD_W-1:0]         quo_signed;
  logic signed [WORD_W-1:0] out_result_nxt;

  assign en          = ~out_valid_r | out_ch.ready;
  assign in_ch.ready = en;

  // capture transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (en) begin
      a_valid_r  <= in_ch.valid;
      a_action_r <= in_ch.action;
      a_opa_r    <= in_ch.operand_a;
      a_opb_r    <= in_ch.operand_b;
    end
  end

  // simple ops, compare, divider operand prep
  always_comb begin
    b_side_nxt        = '0;
    b_side_nxt.valid  = a_valid_r;
    b_side_nxt.action = a_action_r;
    b_side_nxt.neg_q  = a_opa_r[WORD_W-1] ^ a_opb_r[WORD_W-1];
    a_mag             = a_opa_r[WORD_W-1] ? (~a_opa_r + 1'b1) : a_opa_r;
    b_dsr_nxt         = a_opb_r[WORD_W-1] ? (~a_opb_r + 1'b1) : a_opb_r;
    b_dvd_nxt         = {a_mag, {FRAC_BITS{1'b0}}};
    unique case (a_action_r)
      ACT_ADD: b_side_nxt.result = a_opa_r + a_opb_r;
      ACT_SUB: b_side_nxt.result = a_opa_r - a_opb_r;
      ACT_INC: b_side_nxt.result = a_opa_r + 32'sd1;
      ACT_DEC: b_side_nxt.result = a_opa_r - 32'sd1;
      ACT_DIV: b_side_nxt.dz     = (a_opb_r == '0);
      ACT_CMP: begin
        b_side_nxt.lt = a_opa_r < a_opb_r;
        b_side_nxt.eq = a_opa_r == a_opb_r;
        b_side_nxt.gt = a_opa_r > a_opb_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_side_r.valid <= 1'b0;
    end else if (en) begin
      b_side_r <= b_side_nxt;
      b_prod_r <= a_opa_r * a_opb_r;
      b_dvd_r  <= b_dvd_nxt;
      b_dsr_r  <= b_dsr_nxt;
    end
  end

  // multiply result drops into the sideband before the divider
  always_comb begin
    prod_shift  = b_prod_r >>> FRAC_BITS;
    div_in_side = b_side_r;
    if (b_side_r.action == ACT_MUL) begin
      div_in_side.result = prod_shift[WORD_W-1:0];
    end
  end

  fpa_div_pipe #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_side  (div_in_side),
    .in_dvd   (b_dvd_r),
    .in_dsr   (b_dsr_r),
    .out_side (div_out_side),
    .out_quo  (div_quo)
  );

  // quotient sign and final select
  always_comb begin
    quo_signed     = div_out_side.neg_q ? (~div_quo + 1'b1) : div_quo;
    out_result_nxt = div_out_side.result;
    if (div_out_side.action == ACT_DIV) begin
      out_result_nxt = div_out_side.dz ? '0 : quo_signed[WORD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r  <= div_out_side.valid;
      out_result_r <= out_result_nxt;
      out_lt_r     <= div_out_side.lt;
      out_eq_r     <= div_out_side.eq;
      out_gt_r     <= div_out_side.gt;
      out_dz_r     <= div_out_side.dz;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.result_value   = out_result_r;
  assign out_ch.less_flag      = out_lt_r;
  assign out_ch.equal_flag     = out_eq_r;
  assign out_ch.greater_flag   = out_gt_r;
  assign out_ch.divide_by_zero = out_dz_r;

endmodule
